[rtl/mzc_pkg.sv]
// Maze carver package: widths, codes, the cell-memory port structs and small tables.
// Used by the channel interfaces, the cell RAM and the top level.
package mzc_pkg;

  localparam int MAX_CELLS  = 1024;
  localparam int MAX_SIDE   = 32;
  localparam int CELL_W     = 10;
  localparam int CNT_W      = 11;
  localparam int DIM_W      = 6;
  localparam int COL_W      = 5;
  localparam int OPEN_W     = 4;
  localparam int RND_W      = 15;
  localparam int REQ_W      = 2;
  localparam int CODE_W     = 3;
  localparam int DIR_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int RECIP_W    = 17;

  typedef logic [CELL_W-1:0]  cell_t;
  typedef logic [OPEN_W-1:0]  open_t;
  typedef logic [DIM_W-1:0]   dim_t;
  typedef logic [DIR_W-1:0]   dir_t;
  typedef logic [CODE_W-1:0]  code_t;

  localparam logic [REQ_W-1:0] REQ_STEP    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RESTART = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START  = 2'd2;

  localparam dir_t DIR_UP    = 2'd0;
  localparam dir_t DIR_DOWN  = 2'd1;
  localparam dir_t DIR_RIGHT = 2'd2;
  localparam dir_t DIR_LEFT  = 2'd3;
  localparam code_t MV_BACK  = 3'd4;

  localparam open_t OPEN_UP    = 4'b0001;
  localparam open_t OPEN_RIGHT = 4'b0010;
  localparam open_t OPEN_DOWN  = 4'b0100;
  localparam open_t OPEN_LEFT  = 4'b1000;

  // ceil(2^17 / 3): exact quotient for any 15-bit word
  localparam logic [15:0] RECIP3 = 16'd43691;

  typedef struct packed {
    logic  en;
    cell_t addr;
  } cell_rd_t;

  typedef struct packed {
    logic  en;
    cell_t addr;
    open_t mask;
    open_t data;
  } cell_wr_t;

  function automatic open_t here_mask(dir_t d);
    open_t m;
    unique case (d)
      DIR_UP:    m = OPEN_UP;
      DIR_DOWN:  m = OPEN_DOWN;
      DIR_RIGHT: m = OPEN_RIGHT;
      DIR_LEFT:  m = OPEN_LEFT;
    endcase
    return m;
  endfunction

  function automatic open_t there_mask(dir_t d);
    open_t m;
    unique case (d)
      DIR_UP:    m = OPEN_DOWN;
      DIR_DOWN:  m = OPEN_UP;
      DIR_RIGHT: m = OPEN_LEFT;
      DIR_LEFT:  m = OPEN_RIGHT;
    endcase
    return m;
  endfunction

  // ceil(2^16 / w); exact column for cells below 1024 and w up to 32
  function automatic logic [RECIP_W-1:0] recip_w(dim_t w);
    logic [RECIP_W-1:0] r;
    unique case (w)
      6'd1:  r = 17'd65536;
      6'd2:  r = 17'd32768;
      6'd3:  r = 17'd21846;
      6'd4:  r = 17'd16384;
      6'd5:  r = 17'd13108;
      6'd6:  r = 17'd10923;
      6'd7:  r = 17'd9363;
      6'd8:  r = 17'd8192;
      6'd9:  r = 17'd7282;
      6'd10: r = 17'd6554;
      6'd11: r = 17'd5958;
      6'd12: r = 17'd5462;
      6'd13: r = 17'd5042;
      6'd14: r = 17'd4682;
      6'd15: r = 17'd4370;
      6'd16: r = 17'd4096;
      6'd17: r = 17'd3856;
      6'd18: r = 17'd3641;
      6'd19: r = 17'd3450;
      6'd20: r = 17'd3277;
      6'd21: r = 17'd3121;
      6'd22: r = 17'd2979;
      6'd23: r = 17'd2850;
      6'd24: r = 17'd2731;
      6'd25: r = 17'd2622;
      6'd26: r = 17'd2521;
      6'd27: r = 17'd2428;
      6'd28: r = 17'd2341;
      6'd29: r = 17'd2260;
      6'd30: r = 17'd2185;
      6'd31: r = 17'd2115;
      default: r = 17'd2048;
    endcase
    return r;
  endfunction

endpackage

[rtl/mzc_ifs.sv]
// Request, result and configuration channel interfaces of the maze carver.
// Depends on mzc_pkg for field widths.
interface mzc_in_if;
  logic                             valid;
  logic                             ready;
  logic [mzc_pkg::REQ_W-1:0]        req_type;
  logic [mzc_pkg::RND_W-1:0]        random_value;
  logic [mzc_pkg::CELL_W-1:0]       cell_index;
  modport source (output valid, req_type, random_value, cell_index, input ready);
  modport sink   (input valid, req_type, random_value, cell_index, output ready);
endinterface

interface mzc_out_if;
  logic                             valid;
  logic                             ready;
  logic [mzc_pkg::CELL_W-1:0]       position;
  logic [mzc_pkg::CODE_W-1:0]       move_code;
  logic                             done_res;
  logic [mzc_pkg::OPEN_W-1:0]       wall_bits;
  modport source (output valid, position, move_code, done_res, wall_bits, input ready);
  modport sink   (input valid, position, move_code, done_res, wall_bits, output ready);
endinterface

interface mzc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [mzc_pkg::CFG_IDX_W-1:0]    reg_index;
  logic [mzc_pkg::CFG_DATA_W-1:0]   wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

[rtl/mzc_cell_ram.sv]
// Cell opening store: two registered read ports, one write port with per-bit enables.
// Depends on mzc_pkg for the port structs.
module mzc_cell_ram (
  input  logic              clk,
  input  mzc_pkg::cell_rd_t rd_a,
  input  mzc_pkg::cell_rd_t rd_b,
  input  mzc_pkg::cell_wr_t wr,
  output mzc_pkg::open_t    rdata_a,
  output mzc_pkg::open_t    rdata_b
);
  import mzc_pkg::*;

  open_t mem [MAX_CELLS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      for (int b = 0; b < OPEN_W; b++) begin
        if (wr.mask[b]) mem[wr.addr][b] <= wr.data[b];
      end
    end
    if (rd_a.en) rdata_a <= mem[rd_a.addr];
    if (rd_b.en) rdata_b <= mem[rd_b.addr];
  end

endmodule

[rtl/maze_carver_backtracker.sv]
// Maze carver top level: depth-first walk sequencer, path stack RAM, output register.
// Depends on mzc_pkg, mzc_ifs and mzc_cell_ram.
// A step runs states NB0, NB1, PICK, FIN; a read or a step on an empty stack runs NB0, FIN; a
// restart runs NB0, CLR, FIN. Two neighbour reads per cycle go to the cell RAM. A new request is
// taken only in IDLE or as FIN registers a result. Reset: control cleared, then a clearing pass
// of the cell RAM with in ready low, as on a restart. Configuration writes are taken at all times.
module maze_carver_backtracker (
  input  logic        clk,
  input  logic        rst_n,
  mzc_in_if.sink      in_ch,
  mzc_out_if.source   out_ch,
  mzc_cfg_if.sink     cfg_ch
);
  import mzc_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_NB0  = 3'd1;
  localparam logic [2:0] ST_NB1  = 3'd2;
  localparam logic [2:0] ST_PICK = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;
  localparam logic [2:0] ST_CLR  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  cell_t cur_r, cur_nxt;
  cell_t clr_cnt_r, clr_cnt_nxt;
  logic clr_emit_r, clr_emit_nxt;

  dim_t height_r, width_r;
  cell_t start_r;
  dim_t eff_h, eff_w, eff_w_r;
  logic [CNT_W-1:0] total_r;

  logic [REQ_W-1:0] req_r;
  logic [RND_W-1:0] rnd_r;
  cell_t idx_r;

  cell_t res_pos_r;
  code_t res_code_r;
  logic res_mov_r, res_pop_r, res_rd_r;

  logic up_ok_r, dn_ok_r, up_free_r, dn_free_r;
  cell_t q_r;
  logic [13:0] q3_r;
  logic [COL_W-1:0] col_r;
  logic [1:0] r3_r;

  logic out_valid_r;
  cell_t out_pos_r;
  code_t out_code_r;
  logic out_done_r;
  open_t out_walls_r;

  cell_rd_t rd_a, rd_b;
  cell_wr_t wr;
  open_t rdata_a, rdata_b;

  cell_t stk_mem [MAX_CELLS];
  cell_t stk_rd_r;
  logic stk_we, stk_re;
  cell_t stk_addr, stk_wdata;

  logic in_acc, fin_go;
  cell_t c, s_clamp, nc;
  logic c_in;
  logic [CNT_W-1:0] cpw, cp1, cnt_m2, total_m1;
  logic [26:0] prod;
  logic [30:0] p3;
  logic [15:0] qw;
  logic [14:0] q3x3;
  logic right_ok, left_ok;
  logic [3:0] free;
  logic [2:0] n;
  logic [1:0] k, seen;
  dir_t dir;
  logic found;

  assign c = cur_r;

  assign eff_h = (height_r == '0) ? 6'd1 :
                 (height_r > DIM_W'(MAX_SIDE)) ? DIM_W'(MAX_SIDE) : height_r;
  assign eff_w = (width_r == '0) ? 6'd1 :
                 (width_r > DIM_W'(MAX_SIDE)) ? DIM_W'(MAX_SIDE) : width_r;

  // config
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r <= 6'd16;
      width_r  <= 6'd16;
      start_r  <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.reg_index)
        CFG_HEIGHT: height_r <= cfg_ch.wdata[DIM_W-1:0];
        CFG_WIDTH:  width_r  <= cfg_ch.wdata[DIM_W-1:0];
        CFG_START:  start_r  <= cfg_ch.wdata[CELL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    eff_w_r <= eff_w;
    total_r <= CNT_W'(eff_h) * CNT_W'(eff_w);
  end

  // handshake
  assign fin_go      = (state_r == ST_FIN) && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = (state_r == ST_IDLE) || fin_go;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // datapath terms
  assign c_in     = {1'b0, c} < total_r;
  assign cpw      = {1'b0, c} + CNT_W'(eff_w_r);
  assign cp1      = {1'b0, c} + 11'd1;
  assign cnt_m2   = count_r - 11'd2;
  assign total_m1 = total_r - 11'd1;
  assign s_clamp  = ({1'b0, start_r} > total_m1) ? total_m1[CELL_W-1:0] : start_r;
  assign prod     = 27'(c) * 27'(recip_w(eff_w_r));
  assign p3       = 31'(rnd_r) * 31'(RECIP3);
  assign qw       = 16'(q_r) * 16'(eff_w_r);
  assign q3x3     = 15'(q3_r) + {q3_r, 1'b0};

  assign right_ok = c_in && (cp1 < total_r) && ({1'b0, col_r} != eff_w_r - 6'd1)
                    && (rdata_a == '0);
  assign left_ok  = c_in && (col_r != '0) && (rdata_b == '0);
  assign free     = {left_ok, right_ok, dn_free_r, up_free_r};
  assign n        = 3'(free[0]) + 3'(free[1]) + 3'(free[2]) + 3'(free[3]);

  always_comb begin
    unique case (n)
      3'd2:    k = {1'b0, rnd_r[0]};
      3'd3:    k = r3_r;
      3'd4:    k = rnd_r[1:0];
      default: k = 2'd0;
    endcase
  end

  always_comb begin
    dir   = DIR_UP;
    found = 1'b0;
    seen  = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (free[i] && !found) begin
        if (seen == k) begin
          dir   = dir_t'(i);
          found = 1'b1;
        end
        seen = seen + 2'd1;
      end
    end
  end

  always_comb begin
    unique case (dir)
      DIR_UP:    nc = c - CELL_W'(eff_w_r);
      DIR_DOWN:  nc = cpw[CELL_W-1:0];
      DIR_RIGHT: nc = cp1[CELL_W-1:0];
      DIR_LEFT:  nc = c - 10'd1;
    endcase
  end

  // memory port control
  always_comb begin
    rd_a      = '0;
    rd_b      = '0;
    wr        = '0;
    stk_we    = 1'b0;
    stk_re    = 1'b0;
    stk_addr  = '0;
    stk_wdata = s_clamp;
    unique case (state_r)
      ST_NB0: begin
        if (req_r == REQ_STEP) begin
          rd_a = '{en: count_r != '0, addr: c - CELL_W'(eff_w_r)};
          rd_b = '{en: count_r != '0, addr: cpw[CELL_W-1:0]};
        end else if (req_r == REQ_RESTART) begin
          stk_we = 1'b1;
        end else begin
          rd_a = '{en: 1'b1, addr: idx_r};
        end
      end
      ST_NB1: begin
        rd_a = '{en: 1'b1, addr: cp1[CELL_W-1:0]};
        rd_b = '{en: 1'b1, addr: c - 10'd1};
      end
      ST_PICK: begin
        if (n != '0) begin
          wr = '{en: 1'b1, addr: c, mask: here_mask(dir), data: '1};
          stk_we    = count_r < CNT_W'(MAX_CELLS);
          stk_addr  = count_r[CELL_W-1:0];
          stk_wdata = nc;
        end else begin
          stk_re   = count_r >= 11'd2;
          stk_addr = cnt_m2[CELL_W-1:0];
        end
      end
      ST_FIN: begin
        if (fin_go && res_mov_r) begin
          wr = '{en: 1'b1, addr: res_pos_r, mask: there_mask(res_code_r[DIR_W-1:0]), data: '1};
        end
      end
      ST_CLR: begin
        wr = '{en: 1'b1, addr: clr_cnt_r, mask: '1, data: '0};
      end
      default: ;
    endcase
  end

  mzc_cell_ram u_cells (
    .clk     (clk),
    .rd_a    (rd_a),
    .rd_b    (rd_b),
    .wr      (wr),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_addr] <= stk_wdata;
    if (stk_re) stk_rd_r <= stk_mem[stk_addr];
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    cur_nxt      = cur_r;
    clr_cnt_nxt  = clr_cnt_r;
    clr_emit_nxt = clr_emit_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_NB0;
      ST_NB0: begin
        priority if (req_r == REQ_RESTART) begin
          count_nxt    = 11'd1;
          cur_nxt      = s_clamp;
          clr_cnt_nxt  = '0;
          clr_emit_nxt = 1'b1;
          state_nxt    = ST_CLR;
        end else if (req_r == REQ_STEP && count_r != '0) begin
          state_nxt = ST_NB1;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_NB1: state_nxt = ST_PICK;
      ST_PICK: begin
        state_nxt = ST_FIN;
        if (n != '0) begin
          if (count_r < CNT_W'(MAX_CELLS)) count_nxt = count_r + 11'd1;
          cur_nxt = nc;
        end else begin
          count_nxt = count_r - 11'd1;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          if (res_pop_r && count_r != '0) cur_nxt = stk_rd_r;
          state_nxt = in_acc ? ST_NB0 : ST_IDLE;
        end
      end
      ST_CLR: begin
        clr_cnt_nxt = clr_cnt_r + 10'd1;
        if (clr_cnt_r == CELL_W'(MAX_CELLS - 1)) begin
          state_nxt = clr_emit_r ? ST_FIN : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLR;
      count_r    <= '0;
      cur_r      <= '0;
      clr_cnt_r  <= '0;
      clr_emit_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      cur_r      <= cur_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
      clr_emit_r <= clr_emit_nxt;
    end
  end

  // request and step payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r <= in_ch.req_type;
      rnd_r <= in_ch.random_value;
      idx_r <= in_ch.cell_index;
    end
    unique case (state_r)
      ST_NB0: begin
        res_mov_r  <= 1'b0;
        res_pop_r  <= 1'b0;
        res_rd_r   <= (req_r != REQ_STEP) && (req_r != REQ_RESTART);
        res_code_r <= (req_r == REQ_STEP) ? MV_BACK : '0;
        res_pos_r  <= (req_r == REQ_STEP) ? c : (req_r == REQ_RESTART) ? s_clamp : idx_r;
        up_ok_r    <= c_in && (c >= CELL_W'(eff_w_r));
        dn_ok_r    <= cpw < total_r;
        q_r        <= prod[25:16];
        q3_r       <= p3[30:17];
      end
      ST_NB1: begin
        up_free_r <= up_ok_r && (rdata_a == '0);
        dn_free_r <= dn_ok_r && (rdata_b == '0);
        col_r     <= COL_W'(16'(c) - qw);
        r3_r      <= 2'(rnd_r - q3x3);
      end
      ST_PICK: begin
        res_mov_r  <= n != '0;
        res_pop_r  <= n == '0;
        res_code_r <= (n != '0) ? {1'b0, dir} : MV_BACK;
        res_pos_r  <= (n != '0) ? nc : c;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_pos_r   <= (res_pop_r && count_r != '0) ? stk_rd_r : res_pos_r;
      out_code_r  <= res_code_r;
      out_done_r  <= count_r == '0;
      out_walls_r <= res_rd_r ? rdata_a : '0;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.position  = out_pos_r;
  assign out_ch.move_code = out_code_r;
  assign out_ch.done_res  = out_done_r;
  assign out_ch.wall_bits = out_walls_r;

endmodule
